>>> rtl/core/dtsn_pkg.sv
package dtsn_pkg;

	// Geometry and storage.
	localparam int MAX_WIDTH  = 1024;
	localparam int DEPTH_BITS = 16;
	localparam int RING_ROWS  = 8;
	localparam int SLOT_W     = $clog2(RING_ROWS);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 11;
	localparam int FOCAL_W    = 24;

	// Arithmetic widths.
	localparam int GRAD_W     = DEPTH_BITS + 3;
	localparam int MAG_W      = DEPTH_BITS + 2;
	localparam int GRAD_SHIFT = 13;
	localparam int PROD_W     = DEPTH_BITS + FOCAL_W;
	localparam int WIDE_W     = (MAG_W + GRAD_SHIFT > PROD_W) ? MAG_W + GRAD_SHIFT : PROD_W;
	localparam int NORM_W     = 30;
	localparam int SH_W       = $clog2(WIDE_W - NORM_W + 1);
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int UNIT_SHIFT = 14;
	localparam int Q_W        = UNIT_SHIFT + 1;
	localparam int NUM_W      = ROOT_W + Q_W - 1;
	localparam int OUT_W      = 16;
	localparam int DT_W       = 15;

	// Register map.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd2;

	localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;
	localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 24'd118;

	// Request kinds on the input stream.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// One column of the window: rows above, at and below the center, and
	// whether any of the five rows holds a reading.
	typedef struct packed {
		logic [DEPTH_BITS-1:0] up;
		logic [DEPTH_BITS-1:0] mid;
		logic [DEPTH_BITS-1:0] dn;
		logic                  nz;
	} dtsn_col_t;

	typedef struct packed {
		dtsn_col_t lf;
		dtsn_col_t ct;
		dtsn_col_t rt;
		logic      empty;
		logic      frame_end;
	} dtsn_win_t;

	// Scaled vector magnitudes with their signs.
	typedef struct packed {
		logic [NORM_W-1:0] a;
		logic [NORM_W-1:0] b;
		logic [NORM_W-1:0] c;
		logic              neg_a;
		logic              neg_b;
		logic              frame_end;
	} dtsn_vec_t;

endpackage

>>> rtl/core/dtsn_ram.sv
module dtsn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/dtsn_window.sv
module dtsn_window import dtsn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic                  in_op,
	input  logic [DEPTH_BITS-1:0] in_depth,
	input  logic                  restart,
	input  logic [COL_W:0]        eff_w,
	input  logic [DIM_W-1:0]      eff_h,
	output logic                  out_valid,
	output dtsn_win_t             out_win
);

	function automatic logic [SLOT_W-1:0] row_slot(input logic signed [DIM_W+1:0] r,
			input logic [DIM_W-1:0] h);
		logic signed [DIM_W+1:0] hmax;
		logic signed [DIM_W+1:0] c;
		hmax = $signed({2'b00, h - DIM_W'(1)});
		if (r < 0) begin
			c = '0;
		end else if (r > hmax) begin
			c = hmax;
		end else begin
			c = r;
		end
		return c[SLOT_W-1:0];
	endfunction

	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [DIM_W-1:0] in_row_q, out_row_q;

	logic                    accept, is_px, px_restart, emit, rd, fl_emit;
	logic [DIM_W-1:0]        px_row, orow;
	logic [COL_W-1:0]        px_col, ocol;
	logic [COL_W:0]          ocol2;
	logic [DIM_W:0]          pr;
	logic [COL_W-1:0]        pc;
	logic signed [DIM_W+1:0] prs;
	logic [SLOT_W-1:0]       sel [5];
	logic                    frame_end;
	logic [3:0]              bnd;
	logic [COL_W-1:0]        ocol_nx;
	logic [DIM_W-1:0]        orow_nx;

	// Stage 1 registers.
	logic                  v_s1, emit_s1, byp_s1, fe_s1;
	logic [SLOT_W-1:0]     sel_s1 [5];
	logic [DEPTH_BITS-1:0] byp_val_s1;
	logic [3:0]            bnd_s1;

	logic [DEPTH_BITS-1:0] rdata [RING_ROWS];
	logic [DEPTH_BITS-1:0] rows [5];
	dtsn_col_t             col_new;
	dtsn_col_t             col_q [4];
	dtsn_col_t             cand [5];
	dtsn_col_t             jm2, jm1, jp1, jp2;

	assign accept = in_valid && en;
	assign is_px  = (in_op == OP_PIXEL);

	// Position of the request: a pixel after a full frame starts over.
	always_comb begin
		px_restart = (in_row_q >= eff_h);
		px_row     = px_restart ? '0 : in_row_q;
		px_col     = px_restart ? '0 : in_col_q;
		fl_emit    = (in_row_q >= eff_h) && (out_row_q < eff_h);
		if (is_px) begin
			emit = (px_row > DIM_W'(2)) || ((px_row == DIM_W'(2)) && (px_col >= COL_W'(2)));
			rd   = (px_row >= DIM_W'(2));
			orow = px_restart ? '0 : out_row_q;
			ocol = px_restart ? '0 : out_col_q;
		end else begin
			emit = fl_emit;
			rd   = fl_emit;
			orow = out_row_q;
			ocol = out_col_q;
		end
	end

	// The column read runs two positions ahead of the output.
	always_comb begin
		ocol2 = {1'b0, ocol} + (COL_W+1)'(2);
		if (is_px) begin
			pr = {1'b0, px_row} - (DIM_W+1)'(2);
			pc = px_col;
		end else if (ocol2 >= eff_w) begin
			pr = {1'b0, orow} + (DIM_W+1)'(1);
			pc = COL_W'(ocol2 - eff_w);
		end else begin
			pr = {1'b0, orow};
			pc = ocol2[COL_W-1:0];
		end
		prs = $signed({1'b0, pr});
		for (int k = 0; k < 5; k++) begin
			sel[k] = row_slot(prs + (DIM_W+2)'(k - 2), eff_h);
		end
	end

	// Output position flags for border replication.
	always_comb begin
		frame_end = (orow == eff_h - DIM_W'(1)) && ({1'b0, ocol} == eff_w - (COL_W+1)'(1));
		bnd[0] = (ocol >= COL_W'(1));
		bnd[1] = (ocol >= COL_W'(2));
		bnd[2] = ({1'b0, ocol} + (COL_W+1)'(1) < eff_w);
		bnd[3] = ({1'b0, ocol} + (COL_W+1)'(2) < eff_w);
		if ({1'b0, ocol} + (COL_W+1)'(1) >= eff_w) begin
			ocol_nx = '0;
			orow_nx = orow + DIM_W'(1);
		end else begin
			ocol_nx = ocol + COL_W'(1);
			orow_nx = orow;
		end
	end

	// Input and output position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (is_px) begin
				if ({1'b0, px_col} + (COL_W+1)'(1) >= eff_w) begin
					in_col_q <= '0;
					in_row_q <= px_row + DIM_W'(1);
				end else begin
					in_col_q <= px_col + COL_W'(1);
					in_row_q <= px_row;
				end
			end
			if (emit) begin
				out_col_q <= ocol_nx;
				out_row_q <= orow_nx;
			end else begin
				out_col_q <= ocol;
				out_row_q <= orow;
			end
		end
	end

	// Ring of row buffers, one memory per row slot.
	for (genvar i = 0; i < RING_ROWS; i++) begin : g_row
		dtsn_ram #(
			.WIDTH(DEPTH_BITS),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (accept && is_px && (px_row[SLOT_W-1:0] == SLOT_W'(i))),
			.waddr(px_col),
			.wdata(in_depth),
			.re   (en),
			.raddr(pc),
			.rdata(rdata[i])
		);
	end

	// Stage 1: memory read in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && rd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emit_s1    <= emit;
			byp_s1     <= is_px;
			byp_val_s1 <= in_depth;
			fe_s1      <= frame_end;
			bnd_s1     <= bnd;
			for (int k = 0; k < 5; k++) begin
				sel_s1[k] <= sel[k];
			end
		end
	end

	// New column; the bottom row of a pixel request is the pixel itself.
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			rows[k] = rdata[sel_s1[k]];
		end
		if (byp_s1) begin
			rows[4] = byp_val_s1;
		end
		col_new.up  = rows[1];
		col_new.mid = rows[2];
		col_new.dn  = rows[3];
		col_new.nz  = (rows[0] != '0) || (rows[1] != '0) || (rows[2] != '0) ||
			(rows[3] != '0) || (rows[4] != '0);
	end

	// Columns of the four earlier positions.
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			col_q[0] <= col_new;
			for (int k = 1; k < 4; k++) begin
				col_q[k] <= col_q[k-1];
			end
		end
	end

	// Pick the window columns, replicating at the left and right edges.
	always_comb begin
		cand[4] = col_new;
		cand[3] = col_q[0];
		cand[2] = col_q[1];
		cand[1] = col_q[2];
		cand[0] = col_q[3];
		jm1 = bnd_s1[0] ? cand[1] : cand[2];
		jm2 = bnd_s1[1] ? cand[0] : jm1;
		jp1 = bnd_s1[2] ? cand[3] : cand[2];
		jp2 = bnd_s1[3] ? cand[4] : jp1;
	end

	// Stage 2: window of the output pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_win.lf        <= jm1;
			out_win.ct        <= cand[2];
			out_win.rt        <= jp1;
			out_win.empty     <= !(jm2.nz || jm1.nz || cand[2].nz || jp1.nz || jp2.nz);
			out_win.frame_end <= fe_s1;
		end
	end

endmodule

>>> rtl/core/dtsn_vector.sv
module dtsn_vector import dtsn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  dtsn_win_t          in_win,
	input  logic [FOCAL_W-1:0] inv_focal,
	output logic               out_valid,
	output logic [SUM_W-1:0]   out_sum,
	output dtsn_vec_t          out_vec
);

	function automatic logic signed [GRAD_W-1:0] ext(input logic [DEPTH_BITS-1:0] x);
		return $signed({3'b000, x});
	endfunction

	logic signed [GRAD_W-1:0] s_sum, t_sum;
	logic [WIDE_W-1:0]        wa, wb, wc, w_any;
	logic [SH_W-1:0]          sh;

	logic              v_s3, neg_a_s3, neg_b_s3, fe_s3;
	logic [MAG_W-1:0]  mag_a_s3, mag_b_s3;
	logic [PROD_W-1:0] dz_s3;

	logic              v_s4, neg_a_s4, neg_b_s4, fe_s4;
	logic [WIDE_W-1:0] wa_s4, wb_s4, wc_s4;
	logic [SH_W-1:0]   sh_s4;

	logic      v_s5, v_s6;
	dtsn_vec_t vec_s5, vec_s6;
	logic [SQ_W-1:0] sqa_s6, sqb_s6, sqc_s6;

	// Sobel sums of the window.
	always_comb begin
		s_sum = ext(in_win.lf.dn) - ext(in_win.lf.up) +
			((ext(in_win.ct.dn) - ext(in_win.ct.up)) <<< 1) +
			ext(in_win.rt.dn) - ext(in_win.rt.up);
		t_sum = ext(in_win.rt.up) - ext(in_win.lf.up) +
			((ext(in_win.rt.mid) - ext(in_win.lf.mid)) <<< 1) +
			ext(in_win.rt.dn) - ext(in_win.lf.dn);
		if (in_win.empty) begin
			s_sum = '0;
			t_sum = '0;
		end
	end

	// Stage 3: magnitudes, signs and depth over focal length.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_a_s3 <= s_sum < 0;
			neg_b_s3 <= t_sum < 0;
			mag_a_s3 <= (s_sum < 0) ? MAG_W'(-s_sum) : MAG_W'(s_sum);
			mag_b_s3 <= (t_sum < 0) ? MAG_W'(-t_sum) : MAG_W'(t_sum);
			dz_s3    <= in_win.ct.mid * inv_focal;
			fe_s3    <= in_win.frame_end;
		end
	end

	// Common shift that brings all three below the normalized range.
	always_comb begin
		wa    = WIDE_W'(mag_a_s3) << GRAD_SHIFT;
		wb    = WIDE_W'(mag_b_s3) << GRAD_SHIFT;
		wc    = WIDE_W'(dz_s3);
		w_any = wa | wb | wc;
		sh    = '0;
		for (int i = NORM_W; i < WIDE_W; i++) begin
			if (w_any[i]) begin
				sh = SH_W'(i - NORM_W + 1);
			end
		end
	end

	// Stage 4: shift amount found.
	always_ff @(posedge clk) begin
		if (en) begin
			wa_s4    <= wa;
			wb_s4    <= wb;
			wc_s4    <= wc;
			sh_s4    <= sh;
			neg_a_s4 <= neg_a_s3;
			neg_b_s4 <= neg_b_s3;
			fe_s4    <= fe_s3;
		end
	end

	// Stage 5: scaled components.
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s5.a         <= NORM_W'(wa_s4 >> sh_s4);
			vec_s5.b         <= NORM_W'(wb_s4 >> sh_s4);
			vec_s5.c         <= NORM_W'(wc_s4 >> sh_s4);
			vec_s5.neg_a     <= neg_a_s4;
			vec_s5.neg_b     <= neg_b_s4;
			vec_s5.frame_end <= fe_s4;
		end
	end

	// Stage 6: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s6 <= vec_s5.a * vec_s5.a;
			sqb_s6 <= vec_s5.b * vec_s5.b;
			sqc_s6 <= vec_s5.c * vec_s5.c;
			vec_s6 <= vec_s5;
		end
	end

	// Stage 7: sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			out_sum <= SUM_W'(sqa_s6) + SUM_W'(sqb_s6) + SUM_W'(sqc_s6);
			out_vec <= vec_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s3      <= in_valid;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

endmodule

>>> rtl/core/dtsn_sqrt.sv
module dtsn_sqrt import dtsn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  in_sum,
	input  dtsn_vec_t         in_vec,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output dtsn_vec_t         out_vec
);

	typedef struct packed {
		logic [SUM_W-1:0] v;
		logic [SUM_W-1:0] res;
		dtsn_vec_t        vec;
	} sq_step_t;

	sq_step_t step_s [SQRT_STEPS+1];
	logic     vld_s  [SQRT_STEPS+1];

	// Entry stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0].v   <= in_sum;
			step_s[0].res <= '0;
			step_s[0].vec <= in_vec;
		end
	end

	// One root bit per stage, highest first.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic [SUM_W:0] trial;

		assign trial = {1'b0, step_s[k].res} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[k+1].vec <= step_s[k].vec;
				if ({1'b0, step_s[k].v} >= trial) begin
					step_s[k+1].v   <= step_s[k].v - trial[SUM_W-1:0];
					step_s[k+1].res <= (step_s[k].res >> 1) + BIT;
				end else begin
					step_s[k+1].v   <= step_s[k].v;
					step_s[k+1].res <= step_s[k].res >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign out_root  = step_s[SQRT_STEPS].res[ROOT_W-1:0];
	assign out_vec   = step_s[SQRT_STEPS].vec;

endmodule

>>> rtl/core/dtsn_div.sv
module dtsn_div import dtsn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] in_root,
	input  dtsn_vec_t         in_vec,
	output logic              out_valid,
	output logic [OUT_W-1:0]  unit_vertical,
	output logic [OUT_W-1:0]  unit_horizontal,
	output logic [DT_W-1:0]   unit_depth_term,
	output logic              frame_end
);

	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][Q_W-1:0]   q;
		logic [ROOT_W-1:0]     n;
		logic                  zero;
		logic                  neg_a;
		logic                  neg_b;
		logic                  frame_end;
	} dv_step_t;

	dv_step_t step_s [Q_W+1];
	logic     vld_s  [Q_W+1];
	dv_step_t last;

	// Entry stage: rounded numerators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0].rem[0]    <= (NUM_W'(in_vec.a) << UNIT_SHIFT) + NUM_W'(in_root >> 1);
			step_s[0].rem[1]    <= (NUM_W'(in_vec.b) << UNIT_SHIFT) + NUM_W'(in_root >> 1);
			step_s[0].rem[2]    <= (NUM_W'(in_vec.c) << UNIT_SHIFT) + NUM_W'(in_root >> 1);
			step_s[0].q         <= '0;
			step_s[0].n         <= in_root;
			step_s[0].zero      <= (in_root == '0);
			step_s[0].neg_a     <= in_vec.neg_a;
			step_s[0].neg_b     <= in_vec.neg_b;
			step_s[0].frame_end <= in_vec.frame_end;
		end
	end

	// One quotient bit per stage for all three lanes.
	for (genvar s = 0; s < Q_W; s++) begin : g_step
		localparam int QB = Q_W - 1 - s;
		logic [NUM_W-1:0] dvs;
		dv_step_t         nx;

		assign dvs = NUM_W'(step_s[s].n) << QB;

		always_comb begin
			nx = step_s[s];
			for (int l = 0; l < 3; l++) begin
				if (step_s[s].rem[l] >= dvs) begin
					nx.rem[l]   = step_s[s].rem[l] - dvs;
					nx.q[l][QB] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[s+1] <= nx;
			end
		end
	end

	assign last = step_s[Q_W];

	// Output register: signs applied, zero vector stays zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frame_end <= last.frame_end;
			if (last.zero) begin
				unit_vertical   <= '0;
				unit_horizontal <= '0;
				unit_depth_term <= '0;
			end else begin
				unit_vertical   <= last.neg_a ? -OUT_W'(last.q[0]) : OUT_W'(last.q[0]);
				unit_horizontal <= last.neg_b ? -OUT_W'(last.q[1]) : OUT_W'(last.q[1]);
				unit_depth_term <= DT_W'(last.q[2]);
			end
		end
	end

endmodule

>>> rtl/core/depth_to_surface_normal_unit.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata depth_sample, tuser op
// m_*       out        m_tvalid / m_tready  tdata unit vector, tlast frame_end
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken every clock while the output is not stalled.
// That rate rests on one read port per row buffer: one column read per request.
// Reset clears the position counters, the valid bits and the registers to their
// defaults; no clearing pass is needed. When the output register holds a result
// that is not taken, the whole pipeline holds and s_tready drops.
module depth_to_surface_normal_unit import dtsn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DEPTH_BITS-1:0] s_tdata,   // [15:0] depth_sample
	input  logic                  s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // [15:0] unit_vertical, [31:16] unit_horizontal,
	                                         // [46:32] unit_depth_term, [47] zero
	output logic                  m_tlast,   // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FOCAL_W-1:0]    cfg_data
);

	logic [DIM_W-1:0]   image_width_q, image_height_q;
	logic [FOCAL_W-1:0] inv_focal_q;
	logic               cfg_wr, restart, en;
	logic [COL_W:0]     eff_w;
	logic [DIM_W-1:0]   eff_h;

	logic             win_valid, vec_valid, sq_valid;
	dtsn_win_t        win;
	logic [SUM_W-1:0] sum;
	dtsn_vec_t        vec, sq_vec;
	logic [ROOT_W-1:0] root;

	logic [OUT_W-1:0] unit_v, unit_h;
	logic [DT_W-1:0]  unit_d;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;

	// Register writes; geometry writes restart the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			inv_focal_q    <= FOCAL_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				CFG_FOCAL:  inv_focal_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		restart = cfg_wr && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));
	end

	// Geometry in use.
	always_comb begin
		if (image_width_q < DIM_W'(3)) begin
			eff_w = (COL_W+1)'(3);
		end else if (image_width_q > DIM_W'(MAX_WIDTH)) begin
			eff_w = (COL_W+1)'(MAX_WIDTH);
		end else begin
			eff_w = (COL_W+1)'(image_width_q);
		end
		eff_h = (image_height_q < DIM_W'(3)) ? DIM_W'(3) : image_height_q;
	end

	dtsn_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_depth (s_tdata),
		.restart  (restart),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.out_valid(win_valid),
		.out_win  (win)
	);

	dtsn_vector u_vector (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (win_valid),
		.in_win   (win),
		.inv_focal(inv_focal_q),
		.out_valid(vec_valid),
		.out_sum  (sum),
		.out_vec  (vec)
	);

	dtsn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec_valid),
		.in_sum   (sum),
		.in_vec   (vec),
		.out_valid(sq_valid),
		.out_root (root),
		.out_vec  (sq_vec)
	);

	dtsn_div u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (sq_valid),
		.in_root        (root),
		.in_vec         (sq_vec),
		.out_valid      (m_tvalid),
		.unit_vertical  (unit_v),
		.unit_horizontal(unit_h),
		.unit_depth_term(unit_d),
		.frame_end      (m_tlast)
	);

	assign m_tdata = {1'b0, unit_d, unit_h, unit_v};

endmodule

>>> test/depth_to_surface_normal_unit_tb.sv
`timescale 1ns / 1ps

module depth_to_surface_normal_unit_tb;
	import dtsn_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int QUIET_CYCLES = 72;
	localparam int CALM_TAIL = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {REQ_PIXEL, REQ_FLUSH, REQ_CFG, REQ_HOLD} req_kind_t;

	typedef struct {
		req_kind_t             kind;
		logic [DEPTH_BITS-1:0] depth;
		logic [CFG_IDX_W-1:0]  idx;
		logic [FOCAL_W-1:0]    data;
	} request_t;

	typedef struct {
		logic [15:0] vert;
		logic [15:0] horiz;
		logic [14:0] dterm;
		logic        last;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DEPTH_BITS-1:0] s_tdata = '0;
	logic s_tuser = OP_PIXEL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
	logic [FOCAL_W-1:0] cfg_data = '0;

	depth_to_surface_normal_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	request_t request_q[$];
	normal_t normal_q[$];
	int errors = 0;
	int cycles = 0;

	// Predictor state: row ring, position counters and registers.
	logic [DEPTH_BITS-1:0] row_ring [RING_ROWS * MAX_WIDTH];
	int unsigned in_col, in_row, out_col, out_row;
	int unsigned reg_width = 640, reg_height = 480, reg_focal = 118;

	function automatic int width_used();
		if (reg_width < 3) return 3;
		if (reg_width > MAX_WIDTH) return MAX_WIDTH;
		return reg_width;
	endfunction

	function automatic int height_used();
		return reg_height < 3 ? 3 : reg_height;
	endfunction

	function automatic longint ring_at(int r, int c);
		int rr, cc;
		rr = r < 0 ? 0 : (r > height_used() - 1 ? height_used() - 1 : r);
		cc = c < 0 ? 0 : (c > width_used() - 1 ? width_used() - 1 : c);
		return longint'(row_ring[(rr % RING_ROWS) * MAX_WIDTH + cc]);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Sobel gradients, erosion mask and normalization for the next output pixel.
	function automatic void push_normal();
		int y, x, sh;
		longint s, t, a, b, wt;
		longint unsigned ua, ub, uc, m, n, ra, rb, rc;
		bit empty;
		normal_t nv;
		y = out_row;
		x = out_col;
		s = 0;
		t = 0;
		empty = 1;
		ra = 0;
		rb = 0;
		rc = 0;
		sh = 0;
		for (int i = -2; i <= 2; i++)
			for (int j = -2; j <= 2; j++)
				if (ring_at(y + i, x + j) != 0) empty = 0;
		for (int i = -1; i <= 1; i++) begin
			wt = (i == 0) ? 2 : 1;
			s += wt * (ring_at(y + 1, x + i) - ring_at(y - 1, x + i));
			t += wt * (ring_at(y + i, x + 1) - ring_at(y + i, x - 1));
		end
		if (empty) begin
			s = 0;
			t = 0;
		end
		a = s * 8192;
		b = t * 8192;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		uc = longint'(ring_at(y, x)) * longint'(reg_focal);
		m = ua > ub ? ua : ub;
		if (uc > m) m = uc;
		while ((m >> sh) >= (64'd1 << 30)) sh++;
		ua >>= sh;
		ub >>= sh;
		uc >>= sh;
		n = int_sqrt(ua * ua + ub * ub + uc * uc);
		if (n != 0) begin
			ra = (ua * 16384 + n / 2) / n;
			rb = (ub * 16384 + n / 2) / n;
			rc = (uc * 16384 + n / 2) / n;
			if (a < 0) ra = -ra;
			if (b < 0) rb = -rb;
		end
		nv.vert = ra[15:0];
		nv.horiz = rb[15:0];
		nv.dterm = rc[14:0];
		nv.last = (y == height_used() - 1) && (x == width_used() - 1);
		normal_q.push_back(nv);
		out_col++;
		if (out_col >= width_used()) begin
			out_col = 0;
			out_row++;
		end
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Advance the predictor by one accepted stream request.
	function automatic void normal_step(request_t rq);
		bit emit;
		if (rq.kind == REQ_FLUSH) begin
			if (in_row >= height_used() && out_row < height_used()) push_normal();
			return;
		end
		if (in_row >= height_used()) restart_frame();
		row_ring[(in_row % RING_ROWS) * MAX_WIDTH + in_col] = rq.depth;
		emit = in_row > 2 || (in_row == 2 && in_col >= 2);
		in_col++;
		if (in_col >= width_used()) begin
			in_col = 0;
			in_row++;
		end
		if (emit) push_normal();
	endfunction

	function automatic void apply_register(request_t rq);
		case (rq.idx)
			CFG_WIDTH: begin
				reg_width = rq.data[DIM_W-1:0];
				restart_frame();
			end
			CFG_HEIGHT: begin
				reg_height = rq.data[DIM_W-1:0];
				restart_frame();
			end
			CFG_FOCAL: reg_focal = rq.data;
			default: ;
		endcase
	endfunction

	// Clock, reset and run limit.
	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("depth_to_surface_normal_unit_tb: errors");
			$finish;
		end
	end

	// Stream and register driver.
	request_t cur_req, cur_cfg, head;
	int gap = 0;
	int quiet = 0;
	bit next_s, next_c, calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				normal_step(cur_req);
				quiet = 0;
			end else if (quiet < 1000) begin
				quiet++;
			end
			if (cfg_valid && cfg_ready) apply_register(cur_cfg);
			calm = request_q.size() < CALM_TAIL;
			if (!((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready))) begin
				next_s = 0;
				next_c = 0;
				if (gap > 0) begin
					gap--;
				end else if (request_q.size() > 0) begin
					head = request_q[0];
					if (head.kind == REQ_PIXEL || head.kind == REQ_FLUSH) begin
						cur_req = request_q.pop_front();
						next_s = 1;
						if (!calm && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 15);
					end else if (quiet >= QUIET_CYCLES && normal_q.size() == 0) begin
						// Registers change only once the pipeline has drained.
						void'(request_q.pop_front());
						if (head.kind == REQ_CFG) begin
							cur_cfg = head;
							next_c = 1;
						end
					end
				end
				s_tvalid <= next_s;
				cfg_valid <= next_c;
				if (next_s) begin
					s_tdata <= cur_req.depth;
					s_tuser <= (cur_req.kind == REQ_FLUSH) ? OP_FLUSH : OP_PIXEL;
				end
				if (next_c) begin
					cfg_index <= cur_cfg.idx;
					cfg_data <= cur_cfg.data;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	int stall = 0;
	normal_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (normal_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast);
				end else begin
					want = normal_q.pop_front();
					if (m_tdata !== {1'b0, want.dterm, want.horiz, want.vert} ||
					    m_tlast !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp v=%h h=%h d=%h last=%b, got v=%h h=%h d=%h x=%b last=%b",
							         want.vert, want.horiz, want.dterm, want.last,
							         m_tdata[15:0], m_tdata[31:16], m_tdata[46:32], m_tdata[47],
							         m_tlast);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (request_q.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus builders.
	int zr0, zr1, zc0, zc1;
	int items_sent = 0;

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [FOCAL_W-1:0] data);
		request_t rq;
		rq.kind = REQ_CFG;
		rq.idx = idx;
		rq.data = data;
		rq.depth = '0;
		request_q.push_back(rq);
	endfunction

	// Geometry words carry random junk above the 11 used bits.
	function automatic void add_geometry(int w, int h);
		add_cfg(CFG_WIDTH, {13'($urandom), 11'(w)});
		add_cfg(CFG_HEIGHT, {13'($urandom), 11'(h)});
	endfunction

	function automatic void add_req(req_kind_t kind, logic [DEPTH_BITS-1:0] d);
		request_t rq;
		rq.kind = kind;
		rq.depth = d;
		rq.idx = CFG_WIDTH;
		rq.data = '0;
		request_q.push_back(rq);
		items_sent++;
	endfunction

	// Styles: full random, zero patch with sparse holes, smooth ramp, extremes only.
	function automatic logic [DEPTH_BITS-1:0] depth_at(int style, int r, int c);
		case (style)
			0: return 16'($urandom);
			1: begin
				if (r >= zr0 && r <= zr1 && c >= zc0 && c <= zc1) return '0;
				if ($urandom_range(0, 7) == 0) return '0;
				return 16'($urandom);
			end
			2: return 16'(1000 + r * 37 + c * 53 + $urandom_range(0, 15));
			default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		endcase
	endfunction

	function automatic void add_frame(int w, int h, int rows, int style, bit drain);
		zr0 = $urandom_range(0, h - 1);
		zr1 = zr0 + $urandom_range(0, 5);
		zc0 = $urandom_range(0, w - 1);
		zc1 = zc0 + $urandom_range(0, 6);
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < w; c++) begin
				// Flushes inside a frame must be ignored.
				if ($urandom_range(0, 19) == 0) add_req(REQ_FLUSH, 16'($urandom));
				add_req(REQ_PIXEL, depth_at(style, r, c));
			end
		if (drain)
			repeat (2 * w + 2 + $urandom_range(0, 3)) add_req(REQ_FLUSH, 16'($urandom));
	endfunction

	function automatic void add_pause();
		request_t rq;
		rq.kind = REQ_HOLD;
		rq.depth = '0;
		rq.idx = CFG_WIDTH;
		rq.data = '0;
		request_q.push_back(rq);
	endfunction

	int w, h;

	initial begin
		// Directed: 3x3 frames, all-zero mask, extremes, early flush, dropped tail.
		add_geometry(3, 3);
		add_cfg(CFG_FOCAL, 24'd118);
		add_req(REQ_FLUSH, 16'hffff);
		for (int i = 0; i < 9; i++) add_req(REQ_PIXEL, 16'h0000);
		repeat (10) add_req(REQ_FLUSH, '0);
		for (int i = 0; i < 9; i++) add_req(REQ_PIXEL, (i % 2) ? 16'hffff : 16'h0000);
		add_pause();
		for (int i = 0; i < 9; i++) add_req(REQ_PIXEL, (i == 4) ? 16'h0001 : 16'hffff);
		repeat (8) add_req(REQ_FLUSH, '0);
		add_cfg(CFG_UNUSED, 24'h5a5a5a);
		add_cfg(CFG_FOCAL, 24'd1);
		add_frame(4, 3, 3, 3, 1);
		add_cfg(CFG_FOCAL, 24'hffffff);
		add_frame(5, 4, 4, 0, 1);

		// Tallest frame, cut short by a geometry write.
		add_cfg(CFG_FOCAL, 24'd118);
		add_geometry(3, 2047);
		add_frame(3, 2047, 40, 2, 0);
		// Undersized geometry acting as 3x3.
		add_geometry(0, 2);
		add_frame(3, 3, 3, 0, 1);
		add_geometry(3, 1024);
		add_frame(3, 1024, 12, 1, 0);

		// Random frames of mostly small sizes.
		while (items_sent < 1050) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 12);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			add_geometry(w, h);
			if (w < 3) w = 3;
			if (h < 3) h = 3;
			case ($urandom_range(0, 3))
				0: add_cfg(CFG_FOCAL, 24'd1);
				1: add_cfg(CFG_FOCAL, 24'hffffff);
				default: add_cfg(CFG_FOCAL, 24'($urandom));
			endcase
			repeat ($urandom_range(1, 3)) begin
				add_frame(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, h) : h,
				          $urandom_range(0, 3), $urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) == 0) add_pause();
			end
		end

		// Drain and settle.
		while (request_q.size() > 0 || s_tvalid || cfg_valid || normal_q.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0) begin
			$display("depth_to_surface_normal_unit_tb: clean");
		end else begin
			$display("depth_to_surface_normal_unit_tb: errors");
		end
		$finish;
	end

endmodule
